FILE: rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
`default_nettype none

package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_WIDTH  = $clog2(DEPTH);
   localparam int CNT_WIDTH  = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_BACK  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [DATA_WIDTH-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] data_out;
      status_type            status;
      logic                  is_empty;
      logic                  is_full;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctl_type;

endpackage

`default_nettype wire

FILE: rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/deq_ctrl.sv
// Controller state machine for the double-ended queue.
`default_nettype none

module deq_ctrl
   import deq_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   output logic      rsp_valid,
   output ctl_type   ctl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
         valid_ff <= (state_in == S_RESP);
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;
   assign ctl.load  = start && !busy_ff;
   assign ctl.exec  = (state_ff == S_EXEC);

`ifndef SYNTHESIS
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> !valid_ff)
      else $error("strobe held for more than one cycle");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> (state_ff == S_EXEC) && busy_ff)
      else $error("accepted item did not enter execute");
`endif

endmodule

`default_nettype wire

FILE: rtl/deq_dpath.sv
// Datapath for the double-ended queue: indices, count, entry store, result.
`default_nettype none

module deq_dpath
   import deq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire ctl_type ctl,
   input  wire req_type req_item,
   output rsp_type      rsp_item
);

   req_type               req_ff;
   logic [IDX_WIDTH-1:0]  front_ff, front_in;
   logic [IDX_WIDTH-1:0]  back_ff, back_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   status_type            status_ff, status_in;
   logic                  rd_ok_ff, rd_ok_in;

   logic                  wr_en;
   logic [IDX_WIDTH-1:0]  wr_addr;
   logic                  rd_en;
   logic [IDX_WIDTH-1:0]  rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   logic [IDX_WIDTH-1:0]  front_inc, front_dec, back_inc, back_dec;
   logic                  empty, full;

   localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign back_inc  = (back_ff == LAST_IDX) ? '0 : back_ff + 1'b1;
   assign back_dec  = (back_ff == '0) ? LAST_IDX : back_ff - 1'b1;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff >= FULL_CNT);

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      rd_ok_in  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = back_ff;
      rd_en     = 1'b0;
      rd_addr   = front_ff;
      if (ctl.exec) begin
         unique case (req_ff.cmd)
            CMD_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  front_in = front_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = back_ff;
                  back_in  = back_inc;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_POP_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = front_ff;
                  front_in = front_inc;
                  count_in = count_ff - 1'b1;
               end
            end
            CMD_POP_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = back_dec;
                  back_in  = back_dec;
                  count_in = count_ff - 1'b1;
               end
            end
            CMD_PEEK_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = front_ff;
               end
            end
            CMD_PEEK_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = back_dec;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
         rd_ok_in = rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_item;
      end
      if (ctl.exec) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
         if (ctl.exec) begin
            rd_ok_ff <= rd_ok_in;
         end
      end
   end

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ff.data_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_item.data_out = rd_ok_ff ? rd_data : '0;
   assign rsp_item.status   = status_ff;
   assign rsp_item.is_empty = empty;
   assign rsp_item.is_full  = full;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count beyond depth");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < FULL_CNT) && (count_in == count_ff + 1'b1))
      else $error("write while full or count not advanced");

   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (count_ff != '0) && ctl.exec)
      else $error("read of empty queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue.
//
//   channel   ports                          handshake
//   request   start, busy, req_item          accepted when start && !busy
//   response  rsp_valid, rsp_item            one-cycle strobe, no back-pressure
//
// Each item passes through accept, execute (index update and one store
// access) and respond (registered store read data). busy is high from the cycle
// after accept through the response cycle, so a new item is taken only once
// the current one has responded.
// Synchronous reset clears indices and count; the store holds no reset value.
// The receiver cannot stall; each result stands for exactly one cycle.
`default_nettype none

module double_ended_queue
   import deq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   ctl_type ctl;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   deq_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

FILE: tb/tb_double_ended_queue.sv
// Self-checking testbench for the bounded double-ended queue.
`timescale 1ns / 100ps

module tb_double_ended_queue;
   import deq_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   logic [DATA_WIDTH-1:0] held_words [DEPTH];
   logic [IDX_WIDTH-1:0]  front_pos;
   logic [IDX_WIDTH-1:0]  back_pos;
   logic [CNT_WIDTH-1:0]  held_count;

   rsp_type pending_outcomes [$];
   int      error_count;
   bit      no_idle;

   double_ended_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [IDX_WIDTH-1:0] step_fwd(input logic [IDX_WIDTH-1:0] i);
      return (i == IDX_WIDTH'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_WIDTH-1:0] step_back(input logic [IDX_WIDTH-1:0] i);
      return (i == '0) ? IDX_WIDTH'(DEPTH - 1) : i - 1'b1;
   endfunction

   function automatic rsp_type apply_command(input req_type r);
      rsp_type o;
      o = '0;
      o.status = ST_OK;
      case (r.cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (held_count == CNT_WIDTH'(DEPTH)) begin
               o.status = ST_FULL;
            end else if (r.cmd == CMD_PUSH_FRONT) begin
               front_pos = step_back(front_pos);
               held_words[front_pos] = r.data_in;
               held_count = held_count + 1'b1;
            end else begin
               held_words[back_pos] = r.data_in;
               back_pos = step_fwd(back_pos);
               held_count = held_count + 1'b1;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
            if (held_count == '0) begin
               o.status = ST_EMPTY;
            end else if (r.cmd == CMD_POP_FRONT) begin
               o.data_out = held_words[front_pos];
               front_pos = step_fwd(front_pos);
               held_count = held_count - 1'b1;
            end else if (r.cmd == CMD_POP_BACK) begin
               back_pos = step_back(back_pos);
               o.data_out = held_words[back_pos];
               held_count = held_count - 1'b1;
            end else if (r.cmd == CMD_PEEK_FRONT) begin
               o.data_out = held_words[front_pos];
            end else begin
               o.data_out = held_words[step_back(back_pos)];
            end
         end
         default: ;
      endcase
      o.is_empty = (held_count == '0);
      o.is_full  = (held_count == CNT_WIDTH'(DEPTH));
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
                                  input logic [DATA_WIDTH-1:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected item", rsp_item.data_out, '0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_item.data_out !== want.data_out)
               report_mismatch("data_out", rsp_item.data_out, want.data_out);
            if (rsp_item.status !== want.status)
               report_mismatch("status", DATA_WIDTH'(rsp_item.status),
                               DATA_WIDTH'(want.status));
            if (rsp_item.is_empty !== want.is_empty)
               report_mismatch("is_empty", DATA_WIDTH'(rsp_item.is_empty),
                               DATA_WIDTH'(want.is_empty));
            if (rsp_item.is_full !== want.is_full)
               report_mismatch("is_full", DATA_WIDTH'(rsp_item.is_full),
                               DATA_WIDTH'(want.is_full));
         end
      end
   end

   task automatic send_item(input cmd_type c, input logic [DATA_WIDTH-1:0] d);
      req_type item;
      int      gap;
      item.cmd     = c;
      item.data_in = d;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_outcomes.push_back(apply_command(item));
   endtask

   function automatic logic [DATA_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return {(DATA_WIDTH/2){2'b10}};
         3:       return {(DATA_WIDTH/2){2'b01}};
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_queue();
      send_item(CMD_POP_FRONT, '1);
      send_item(CMD_POP_BACK, '0);
      send_item(CMD_PEEK_FRONT, '1);
      send_item(CMD_PEEK_BACK, $urandom);
   endtask

   task automatic test_fill_and_overflow();
      for (int i = 0; i < DEPTH; i++)
         send_item(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_word());
      send_item(CMD_PUSH_FRONT, '1);
      send_item(CMD_PUSH_BACK, '0);
      send_item(CMD_PEEK_FRONT, $urandom);
      send_item(CMD_PEEK_BACK, $urandom);
      send_item(CMD_POP_FRONT, $urandom);
      send_item(CMD_POP_BACK, $urandom);
   endtask

   task automatic test_random_traffic(input int n_items);
      int sent;
      int run_len;
      int push_pct;
      sent = 0;
      while (sent < n_items) begin
         run_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0:       push_pct = 15;
            1:       push_pct = 50;
            default: push_pct = 85;
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < run_len && sent < n_items; i++) begin
            if ($urandom_range(0, 99) < push_pct) begin
               send_item($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_word());
            end else begin
               case ($urandom_range(0, 3))
                  0:       send_item(CMD_POP_FRONT, $urandom);
                  1:       send_item(CMD_POP_BACK, $urandom);
                  2:       send_item(CMD_PEEK_FRONT, $urandom);
                  default: send_item(CMD_PEEK_BACK, $urandom);
               endcase
            end
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      front_pos   = '0;
      back_pos    = '0;
      held_count  = '0;
      error_count = 0;
      no_idle     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_fill_and_overflow();
      test_random_traffic(1750);

      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
